// File: src/qdsl_pkg.sv
`default_nettype none

package qdsl_pkg;

  localparam int unsigned LevelBitsDefault = 10;

  localparam logic [15:0] ValidCodes = 16'h6996;
  localparam logic [7:0]  HistUp     = 8'hE8;
  localparam logic [7:0]  HistDown   = 8'h2B;

  localparam int unsigned LevelAtReset = 500;
  localparam int unsigned MinAtReset   = 24;
  localparam int unsigned MaxAtReset   = 980;
  localparam logic [7:0]  StepAtReset  = 8'd32;

  localparam int unsigned CfgIndexBits = 2;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_STEP_SIZE = 2'd0,
    CFG_MIN_LEVEL = 2'd1,
    CFG_MAX_LEVEL = 2'd2
  } cfg_index_e;

  localparam logic signed [1:0] DirNone = 2'sb00;
  localparam logic signed [1:0] DirUp   = 2'sb01;
  localparam logic signed [1:0] DirDown = 2'sb11;

endpackage

`default_nettype wire

// File: src/quadrature_dimmer_square_law.sv
// an accepted sample goes through the middle stage register and then the output register
// throughput: one sample per cycle while in_stall_o is low; the level update register
//   feeds back to itself, and the squaring stage is a separate register stage after it
// reset (rst_ni low, asynchronous): pipeline empty, transition code and history
//   cleared, level 500, step_size 32, min_level 24, max_level 980
`default_nettype none

module quadrature_dimmer_square_law
  import qdsl_pkg::*;
#(
  parameter int unsigned LEVEL_BITS = LevelBitsDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,

  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIndexBits-1:0] cfg_index_i,
  input  wire logic [LEVEL_BITS-1:0]   cfg_data_i,

  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              quadrature_i,

  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [LEVEL_BITS-1:0]        duty_o,
  output logic signed [1:0]            direction_o,
  output logic [LEVEL_BITS-1:0]        level_o
);

  localparam int unsigned SumBits = LEVEL_BITS + 2;

  // configuration
  logic [7:0]            step_q;
  logic [LEVEL_BITS-1:0] min_q;
  logic [LEVEL_BITS-1:0] max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepAtReset;
      min_q  <= LEVEL_BITS'(MinAtReset);
      max_q  <= LEVEL_BITS'(MaxAtReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_STEP_SIZE: step_q <= cfg_data_i[7:0];
        CFG_MIN_LEVEL: min_q  <= cfg_data_i;
        CFG_MAX_LEVEL: max_q  <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // pipeline control
  logic mid_valid_q;
  logic out_valid_q;
  logic out_load;
  logic mid_load;

  assign out_load    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = mid_valid_q && !out_load;
  assign mid_load    = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mid_load) begin
        mid_valid_q <= 1'b1;
      end else if (out_load) begin
        mid_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= mid_valid_q;
      end
    end
  end

  // decoder and level update
  logic [3:0]            code_q;
  logic [3:0]            code_d;
  logic [7:0]            hist_q;
  logic [7:0]            hist_d;
  logic [LEVEL_BITS-1:0] level_q;
  logic [LEVEL_BITS-1:0] level_d;
  logic signed [1:0]     dir;
  logic [SumBits-1:0]    base_ext;
  logic [SumBits-1:0]    step_ext;
  logic signed [SumBits-1:0] sum;

  always_comb begin
    code_d   = {code_q[1:0], quadrature_i};
    hist_d   = hist_q;
    dir      = DirNone;
    if (ValidCodes[code_d]) begin
      hist_d = {hist_q[3:0], code_d};
      if (hist_d == HistUp) begin
        dir = DirUp;
      end else if (hist_d == HistDown) begin
        dir = DirDown;
      end
    end

    base_ext = {2'b00, level_q};
    step_ext = {{(SumBits-8){1'b0}}, step_q};
    if (dir == DirUp) begin
      sum = $signed(base_ext + step_ext);
    end else if (dir == DirDown) begin
      sum = $signed(base_ext - step_ext);
    end else begin
      sum = $signed(base_ext);
    end

    // lower bound wins, upper bound only checked otherwise
    if (sum < $signed({2'b00, min_q})) begin
      level_d = min_q;
    end else if (sum > $signed({2'b00, max_q})) begin
      level_d = max_q;
    end else begin
      level_d = sum[LEVEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= '0;
      hist_q  <= '0;
      level_q <= LEVEL_BITS'(LevelAtReset);
    end else if (mid_load) begin
      code_q  <= code_d;
      hist_q  <= hist_d;
      level_q <= level_d;
    end
  end

  // middle stage payload
  logic [LEVEL_BITS-1:0] mid_level_q;
  logic signed [1:0]     mid_dir_q;

  always_ff @(posedge clk_i) begin
    if (mid_load) begin
      mid_level_q <= level_d;
      mid_dir_q   <= dir;
    end
  end

  // square law and output register
  logic [2*LEVEL_BITS-1:0] square;
  logic [LEVEL_BITS-1:0]   duty_d;
  logic [LEVEL_BITS-1:0]   duty_q;
  logic signed [1:0]       dir_q;
  logic [LEVEL_BITS-1:0]   out_level_q;

  // full scale minus the top half of the square is its complement
  assign square = {{LEVEL_BITS{1'b0}}, mid_level_q} * {{LEVEL_BITS{1'b0}}, mid_level_q};
  assign duty_d = ~square[2*LEVEL_BITS-1:LEVEL_BITS];

  always_ff @(posedge clk_i) begin
    if (out_load && mid_valid_q) begin
      duty_q      <= duty_d;
      dir_q       <= mid_dir_q;
      out_level_q <= mid_level_q;
    end
  end

  assign duty_o      = duty_q;
  assign direction_o = dir_q;
  assign level_o     = out_level_q;

endmodule

`default_nettype wire

// File: tb/tb_quadrature_dimmer_square_law.sv
`timescale 1ns / 100ps

module tb_quadrature_dimmer_square_law;
  import qdsl_pkg::*;

  localparam int unsigned LB = LevelBitsDefault;
  localparam int unsigned ClkPeriod = 8;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned PrintCap = 200;
  localparam logic [CfgIndexBits-1:0] CfgUnused = 2'd3;
  localparam logic [LB-1:0] LevelFull = '1;

  typedef struct packed {
    logic [LB-1:0]      duty;
    logic signed [1:0]  direction;
    logic [LB-1:0]      level;
  } dimmer_out_t;

  class dimmer_scoreboard;
    logic [7:0]    step_size;
    logic [LB-1:0] min_level;
    logic [LB-1:0] max_level;
    logic [3:0]    trans_code;
    logic [7:0]    history;
    logic [LB-1:0] level;
    dimmer_out_t   pending_q[$];
    int unsigned   mismatches;

    function new();
      step_size  = StepAtReset;
      min_level  = LB'(MinAtReset);
      max_level  = LB'(MaxAtReset);
      trans_code = '0;
      history    = '0;
      level      = LB'(LevelAtReset);
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIndexBits-1:0] idx, logic [LB-1:0] data);
      case (idx)
        CFG_STEP_SIZE: step_size = data[7:0];
        CFG_MIN_LEVEL: min_level = data;
        CFG_MAX_LEVEL: max_level = data;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [1:0] q);
      dimmer_out_t   r;
      int            lvl;
      logic [2*LB-1:0] sq;
      trans_code = {trans_code[1:0], q};
      r.direction = DirNone;
      // bounce and skipped states leave the history alone
      if (ValidCodes[trans_code]) begin
        history = {history[3:0], trans_code};
        if (history == HistUp) begin
          r.direction = DirUp;
        end else if (history == HistDown) begin
          r.direction = DirDown;
        end
      end
      lvl = int'(level);
      if (r.direction == DirUp) begin
        lvl = lvl + int'(step_size);
      end else if (r.direction == DirDown) begin
        lvl = lvl - int'(step_size);
      end
      // min wins first, max only checked otherwise
      if (lvl < int'(min_level)) begin
        lvl = int'(min_level);
      end else if (lvl > int'(max_level)) begin
        lvl = int'(max_level);
      end
      level = lvl[LB-1:0];
      sq = {{LB{1'b0}}, level} * {{LB{1'b0}}, level};
      r.level = level;
      r.duty = LevelFull - sq[2*LB-1:LB];
      pending_q.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PrintCap) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endtask

    task check_result(logic [LB-1:0] duty, logic signed [1:0] dir, logic [LB-1:0] lvl);
      dimmer_out_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unrequested result duty %0d dir %0d level %0d", duty, dir, lvl));
        return;
      end
      want = pending_q.pop_front();
      if (duty !== want.duty) begin
        report($sformatf("duty %0d, predicted %0d", duty, want.duty));
      end
      if (dir !== want.direction) begin
        report($sformatf("direction %0d, predicted %0d", dir, want.direction));
      end
      if (lvl !== want.level) begin
        report($sformatf("level %0d, predicted %0d", lvl, want.level));
      end
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIndexBits-1:0] cfg_index_i;
  logic [LB-1:0]           cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              quadrature_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [LB-1:0]           duty_o;
  logic signed [1:0]       direction_o;
  logic [LB-1:0]           level_o;

  dimmer_scoreboard sb = new();
  bit               no_idle = 1'b0;
  int unsigned      stall_left = 0;
  int unsigned      cycles = 0;

  quadrature_dimmer_square_law uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .quadrature_i (quadrature_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .duty_o       (duty_o),
    .direction_o  (direction_o),
    .level_o      (level_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // accepted requests on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_sample(quadrature_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(duty_o, direction_o, level_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [LB-1:0] pick_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return LevelFull;
      default: return LB'($urandom_range(0, 2**LB - 1));
    endcase
  endfunction

  function automatic logic [LB-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return LB'(8'hFF);
      // upper bits are dropped by the block
      2: return LB'($urandom_range(0, 2**LB - 1));
      default: return LB'($urandom_range(1, 64));
    endcase
  endfunction

  // valid stays high when the next request follows without a gap
  task automatic send_sample(logic [1:0] q);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    quadrature_i <= q;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic cfg_write(logic [CfgIndexBits-1:0] idx, logic [LB-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one edge first so the last accepted request is already noted
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // walk the gray ring, mostly in one direction, with bounce and noise
  task automatic run_phase(int unsigned n);
    logic [1:0]  ring [4] = '{2'd0, 2'd1, 2'd3, 2'd2};
    int unsigned pos;
    int unsigned r;
    bit          up;
    pos = $urandom_range(0, 3);
    up = $urandom_range(0, 1);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        up = !up;
      end
      if (r < 85) begin
        pos = up ? (pos + 1) % 4 : (pos + 3) % 4;
        send_sample(ring[pos]);
      end else if (r < 92) begin
        pos = up ? (pos + 3) % 4 : (pos + 1) % 4;
        send_sample(ring[pos]);
      end else if (r < 96) begin
        send_sample(ring[pos]);
      end else begin
        send_sample(2'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    logic [1:0]    seq_bounce [9] = '{2'd3, 2'd2, 2'd0, 2'd0, 2'd2, 2'd3, 2'd0, 2'd3, 2'd1};
    logic [1:0]    seq_up [11] = '{2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd2, 2'd0,
                                   2'd1, 2'd3, 2'd2, 2'd0};
    logic [1:0]    seq_down [6] = '{2'd2, 2'd3, 2'd1, 2'd0, 2'd2, 2'd3};
    logic [LB-1:0] lo;
    logic [LB-1:0] hi;
    logic [LB-1:0] swap;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_STEP_SIZE;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    quadrature_i <= 2'd0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: one detent each way, then invalid codes
    foreach (seq_bounce[i]) send_sample(seq_bounce[i]);
    drain();

    // widest range and largest step, runs into the top clamp
    cfg_write(CFG_STEP_SIZE, LB'(8'hFF));
    cfg_write(CFG_MIN_LEVEL, '0);
    cfg_write(CFG_MAX_LEVEL, LevelFull);
    cfg_write(CfgUnused, LevelFull);
    foreach (seq_up[i]) send_sample(seq_up[i]);
    drain();

    // min above max: below min lands on min, otherwise above max lands on max
    cfg_write(CFG_MIN_LEVEL, LB'(600));
    cfg_write(CFG_MAX_LEVEL, LB'(100));
    foreach (seq_down[i]) send_sample(seq_down[i]);
    drain();

    for (int p = 0; p < 8; p++) begin
      no_idle = (p == 2) || ($urandom_range(0, 5) == 0);
      lo = pick_level();
      hi = pick_level();
      if (lo > hi && $urandom_range(0, 3) != 0) begin
        swap = lo;
        lo = hi;
        hi = swap;
      end
      cfg_write(CFG_STEP_SIZE, pick_step());
      cfg_write(CFG_MIN_LEVEL, lo);
      cfg_write(CFG_MAX_LEVEL, hi);
      run_phase(75);
      drain();
    end
    no_idle = 1'b0;

    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
